// ----- hw/rtl/cc20_pkg.sv -----
// Shared types, constants and ChaCha20 round functions for the stream XOR core.
// Used by cc20_ctrl, cc20_datapath and chacha20_stream_xor_core; no dependencies.
`default_nettype none

package cc20_pkg;

    localparam int DATA_W    = 64;
    localparam int CNT_W     = 4;
    localparam int TDATA_W   = 72;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 3;
    localparam int SLOTS     = 8;

    localparam int DOUBLE_ROUNDS_DEF  = 10;
    localparam int BYTES_PER_ITEM_DEF = 8;

    localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

    typedef logic [15:0][WORD_W-1:0] cc20_words_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCE0 = 3'd4,
        REG_NONCE1 = 3'd5,
        REG_START  = 3'd6
    } cc20_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } cc20_state_t;

    typedef struct packed {
        logic take_direct;  // accept an item, answer from the current block
        logic take_gen;     // accept an item, load state for a new block
        logic round_en;     // apply one round to the working state
        logic diag;         // 0: column round, 1: diagonal round
        logic finish;       // feed-forward add, store the keystream block
        logic emit;         // answer the held item from the fresh block
    } cc20_cmd_t;

    typedef struct packed {
        logic need_block;   // item at the input needs a new block first
        logic out_free;     // output register can take a result this cycle
    } cc20_status_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Quarter round on four words, returned as {a, b, c, d}.
    function automatic logic [4*WORD_W-1:0] quarter(
        input logic [WORD_W-1:0] a_in,
        input logic [WORD_W-1:0] b_in,
        input logic [WORD_W-1:0] c_in,
        input logic [WORD_W-1:0] d_in
    );
        logic [WORD_W-1:0] a, b, c, d;
        a = a_in; b = b_in; c = c_in; d = d_in;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // One round: four independent quarter rounds on columns or diagonals.
    function automatic cc20_words_t chacha_round(input cc20_words_t w, input logic diag);
        cc20_words_t r;
        logic [4*WORD_W-1:0] q0, q1, q2, q3;
        r = w;
        if (!diag) begin
            q0 = quarter(w[0], w[4], w[8],  w[12]);
            q1 = quarter(w[1], w[5], w[9],  w[13]);
            q2 = quarter(w[2], w[6], w[10], w[14]);
            q3 = quarter(w[3], w[7], w[11], w[15]);
            {r[0], r[4], r[8],  r[12]} = q0;
            {r[1], r[5], r[9],  r[13]} = q1;
            {r[2], r[6], r[10], r[14]} = q2;
            {r[3], r[7], r[11], r[15]} = q3;
        end
        else begin
            q0 = quarter(w[0], w[5], w[10], w[15]);
            q1 = quarter(w[1], w[6], w[11], w[12]);
            q2 = quarter(w[2], w[7], w[8],  w[13]);
            q3 = quarter(w[3], w[4], w[9],  w[14]);
            {r[0], r[5], r[10], r[15]} = q0;
            {r[1], r[6], r[11], r[12]} = q1;
            {r[2], r[7], r[8],  r[13]} = q2;
            {r[3], r[4], r[9],  r[14]} = q3;
        end
        return r;
    endfunction

    function automatic cc20_words_t init_state(
        input logic [3:0][CFG_W-1:0] key,
        input logic [CFG_W-1:0]      nonce_lo,
        input logic [WORD_W-1:0]     nonce_hi,
        input logic [WORD_W-1:0]     ctr
    );
        cc20_words_t s;
        s[0] = SIGMA0;
        s[1] = SIGMA1;
        s[2] = SIGMA2;
        s[3] = SIGMA3;
        for (int p = 0; p < 4; p++) begin
            s[4 + 2*p] = key[p][WORD_W-1:0];
            s[5 + 2*p] = key[p][CFG_W-1:WORD_W];
        end
        s[12] = ctr;
        s[13] = nonce_lo[WORD_W-1:0];
        s[14] = nonce_lo[CFG_W-1:WORD_W];
        s[15] = nonce_hi;
        return s;
    endfunction

    // Byte lanes below the count are kept.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
        logic [DATA_W-1:0] m;
        for (int k = 0; k < DATA_W/8; k++) begin
            m[8*k +: 8] = (CNT_W'(k) < cnt) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chacha20_stream_xor_core.sv -----
// Top level of the ChaCha20 (IETF) stream XOR core.
// Depends on cc20_pkg, cc20_ctrl and cc20_datapath.
//
//  Channel   Signals                         Payload
//  cfg       cfg_valid/cfg_ready             cfg_index (register), cfg_data (value)
//  s_axis    s_axis_tvalid/s_axis_tready     tdata: data_in, byte_count; tuser: first
//  m_axis    m_axis_tvalid/m_axis_tready     tdata: data_out, out_byte_count
//
// An item served from the current keystream block is answered directly. An item that
// needs a new block goes through accept, one round per cycle on a unit of four
// parallel quarter rounds, the feed-forward add, then the result; no new item is
// taken meanwhile. A block covers eight items.
// After reset the stream starts at block counter zero; no clearing pass is needed.
// A stalled output holds its register; the next item is taken once it drains.

`default_nettype none

module chacha20_stream_xor_core #(
    parameter int DOUBLE_ROUNDS  = cc20_pkg::DOUBLE_ROUNDS_DEF,
    parameter int BYTES_PER_ITEM = cc20_pkg::BYTES_PER_ITEM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cc20_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [cc20_pkg::TDATA_W-1:0]    s_axis_tdata,  // data_in[63:0], byte_count[67:64]
    input  wire logic                            s_axis_tuser,  // first
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [cc20_pkg::TDATA_W-1:0]         m_axis_tdata   // data_out[63:0], out_byte_count[67:64]
);
    import cc20_pkg::*;

    cc20_cmd_t    cmd;
    cc20_status_t status;

    cc20_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    cc20_datapath #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/cc20_ctrl.sv -----
// Sequencer for the ChaCha20 stream XOR core: accepts items, runs the round loop.
// Depends on cc20_pkg; drives cc20_datapath through cc20_cmd_t.
`default_nettype none

module cc20_ctrl #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire cc20_pkg::cc20_status_t  status,
    output cc20_pkg::cc20_cmd_t          cmd
);
    import cc20_pkg::*;

    localparam int NUM_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RCNT_W     = $clog2(NUM_ROUNDS);

    cc20_state_t        state_reg, state_next;
    logic [RCNT_W-1:0]  rcnt_reg, rcnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rcnt_next     = rcnt_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = status.out_free;
                if (s_axis_tvalid && status.out_free)
                begin
                    if (status.need_block)
                    begin
                        cmd.take_gen = 1'b1;
                        rcnt_next    = '0;
                        state_next   = ST_ROUND;
                    end
                    else
                    begin
                        cmd.take_direct = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.diag     = rcnt_reg[0];
                if (rcnt_reg == RCNT_W'(NUM_ROUNDS - 1))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            ST_FINAL:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cc20_datapath.sv -----
// Datapath of the ChaCha20 stream XOR core: configuration, round state, keystream
// block, counter and slot, output register. Depends on cc20_pkg.
`default_nettype none

module cc20_datapath #(
    parameter int BYTES_PER_ITEM = cc20_pkg::BYTES_PER_ITEM_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cc20_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic [cc20_pkg::TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [cc20_pkg::TDATA_W-1:0]          m_axis_tdata,
    input  wire cc20_pkg::cc20_cmd_t              cmd,
    output cc20_pkg::cc20_status_t                status
);
    import cc20_pkg::*;

    // configuration
    logic [3:0][CFG_W-1:0] key_reg;
    logic [CFG_W-1:0]      nonce_lo_reg;
    logic [WORD_W-1:0]     nonce_hi_reg;
    logic [WORD_W-1:0]     start_reg;

    // stream state
    logic [WORD_W-1:0]     counter_reg, counter_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  ready_reg, ready_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [SLOTS-1:0][DATA_W-1:0] ks_reg;
    cc20_words_t                  w_reg;
    logic [DATA_W-1:0]            hold_data_reg;
    logic [CNT_W-1:0]             hold_cnt_reg;
    logic [DATA_W-1:0]            out_data_reg;
    logic [CNT_W-1:0]             out_cnt_reg;

    logic [DATA_W-1:0]     in_data;
    logic [CNT_W-1:0]      in_cnt;
    logic [CNT_W-1:0]      cnt_sat;
    logic [WORD_W-1:0]     gen_counter;
    cc20_words_t           init_words;
    cc20_words_t           gen_words;

    assign in_data     = s_axis_tdata[DATA_W-1:0];
    assign in_cnt      = s_axis_tdata[DATA_W+CNT_W-1:DATA_W];
    assign cnt_sat     = (in_cnt > CNT_W'(BYTES_PER_ITEM)) ? CNT_W'(BYTES_PER_ITEM) : in_cnt;
    assign gen_counter = s_axis_tuser ? start_reg : counter_reg;
    assign init_words  = init_state(key_reg, nonce_lo_reg, nonce_hi_reg, counter_reg);
    assign gen_words   = init_state(key_reg, nonce_lo_reg, nonce_hi_reg, gen_counter);

    assign cfg_ready         = 1'b1;
    assign status.need_block = (cnt_sat != '0) && (s_axis_tuser || !ready_reg);
    assign status.out_free   = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - DATA_W - CNT_W){1'b0}}, out_cnt_reg, out_data_reg};

    always_comb
    begin
        counter_next   = counter_reg;
        slot_next      = slot_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (cmd.take_direct)
        begin
            out_valid_next = 1'b1;
            if (cnt_sat == '0)
            begin
                // empty item: the stream state changes only on a restart
                if (s_axis_tuser)
                begin
                    counter_next = start_reg;
                    slot_next    = '0;
                    ready_next   = 1'b0;
                end
            end
            else
            begin
                slot_next  = slot_reg + 1'b1;
                ready_next = (slot_next != '0);
            end
        end
        if (cmd.take_gen)
        begin
            counter_next = gen_counter;
        end
        if (cmd.finish)
        begin
            counter_next = counter_reg + 1'b1;
            slot_next    = '0;
            ready_next   = 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            slot_next      = slot_reg + 1'b1;
            ready_next     = (slot_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nonce_lo_reg  <= '0;
            nonce_hi_reg  <= '0;
            start_reg     <= '0;
            counter_reg   <= '0;
            slot_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            slot_reg      <= slot_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cc20_reg_t'(cfg_index))
                    REG_KEY0:   key_reg[0]   <= cfg_data;
                    REG_KEY1:   key_reg[1]   <= cfg_data;
                    REG_KEY2:   key_reg[2]   <= cfg_data;
                    REG_KEY3:   key_reg[3]   <= cfg_data;
                    REG_NONCE0: nonce_lo_reg <= cfg_data;
                    REG_NONCE1: nonce_hi_reg <= cfg_data[WORD_W-1:0];
                    REG_START:  start_reg    <= cfg_data[WORD_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_direct)
        begin
            out_data_reg <= (in_data ^ ks_reg[slot_reg]) & byte_mask(cnt_sat);
            out_cnt_reg  <= cnt_sat;
        end
        if (cmd.take_gen)
        begin
            w_reg         <= gen_words;
            hold_data_reg <= in_data;
            hold_cnt_reg  <= cnt_sat;
        end
        if (cmd.round_en)
        begin
            w_reg <= chacha_round(w_reg, cmd.diag);
        end
        if (cmd.finish)
        begin
            // add the input state back in and pack word pairs into slots
            for (int i = 0; i < SLOTS; i++)
            begin
                ks_reg[i] <= {w_reg[2*i+1] + init_words[2*i+1], w_reg[2*i] + init_words[2*i]};
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= (hold_data_reg ^ ks_reg[slot_reg]) & byte_mask(hold_cnt_reg);
            out_cnt_reg  <= hold_cnt_reg;
        end
    end

endmodule

`default_nettype wire
